// ===== src/vpt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package vpt_pkg;

    localparam int CYCLES_PER_PERCENT = 16;

    // Largest run count magnitude is 103 percent worth of ticks.
    localparam int RUN_MAX = 103 * CYCLES_PER_PERCENT;
    localparam int RUN_W   = $clog2(RUN_MAX + 1) + 1;
    localparam int PHASE_W = (CYCLES_PER_PERCENT > 1) ? $clog2(CYCLES_PER_PERCENT) : 1;

    localparam int POS_W    = 7;
    localparam int TARGET_W = 7;
    localparam int REM_W    = 12;
    localparam int DIFF_W   = 9;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_SET  = 1'b1;

    localparam logic [POS_W-1:0] POS_FULL   = POS_W'(100);
    localparam logic [POS_W-1:0] POS_CLOSED = POS_W'(0);

    localparam logic signed [DIFF_W-1:0] TARGET_OVER_OPEN  = DIFF_W'(103);
    localparam logic signed [DIFF_W-1:0] TARGET_OVER_CLOSE = -DIFF_W'(3);
    localparam logic signed [DIFF_W-1:0] DIFF_LIMIT_HI     = DIFF_W'(103);
    localparam logic signed [DIFF_W-1:0] DIFF_LIMIT_LO     = -DIFF_W'(103);

    localparam logic signed [31:0] REM_HI = 32'sd2047;
    localparam logic signed [31:0] REM_LO = -32'sd2048;

    typedef struct packed {
        logic                    op;
        logic [TARGET_W-1:0]     target;
    } request_t;

    typedef struct packed {
        logic                    open_drive;
        logic                    close_drive;
        logic [POS_W-1:0]        position;
        logic signed [REM_W-1:0] remaining;
    } result_t;

endpackage

`default_nettype wire

// ===== src/vpt_in_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none

module vpt_in_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire vpt_pkg::request_t in_req,
    input  wire logic              advance,
    output logic                   req_valid,
    output vpt_pkg::request_t      req
);

    logic              valid_reg;
    logic              valid_next;
    vpt_pkg::request_t req_reg;

    // The held request leaves when the output side can take its result.
    assign in_stall   = valid_reg && !advance;
    assign valid_next = in_stall ? valid_reg : in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            req_reg <= in_req;
        end
    end

    assign req_valid = valid_reg;
    assign req       = req_reg;

endmodule

`default_nettype wire

// ===== src/vpt_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module vpt_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              fire,
    input  wire vpt_pkg::request_t req,
    output vpt_pkg::result_t       result
);

    logic signed [vpt_pkg::RUN_W-1:0]  run_reg;
    logic signed [vpt_pkg::RUN_W-1:0]  run_next;
    logic [vpt_pkg::PHASE_W-1:0]       phase_reg;
    logic [vpt_pkg::PHASE_W-1:0]       phase_next;
    logic [vpt_pkg::POS_W-1:0]         pos_reg;
    logic [vpt_pkg::POS_W-1:0]         pos_next;
    logic                              open_reg;
    logic                              open_next;
    logic                              close_reg;
    logic                              close_next;

    logic signed [vpt_pkg::DIFF_W-1:0] goal;
    logic signed [vpt_pkg::DIFF_W-1:0] diff;
    logic signed [vpt_pkg::DIFF_W-1:0] diff_clamped;
    logic signed [vpt_pkg::RUN_W-1:0]  diff_ext;
    logic                              on_boundary;
    logic [vpt_pkg::PHASE_W-1:0]       phase_step;
    logic signed [31:0]                run_wide;

    // The phase tracks the run count magnitude modulo the ticks per percent.
    assign on_boundary = (phase_reg == '0);
    assign phase_step  = on_boundary ? vpt_pkg::PHASE_W'(vpt_pkg::CYCLES_PER_PERCENT - 1)
                                     : phase_reg - vpt_pkg::PHASE_W'(1);

    always_comb
    begin
        goal = vpt_pkg::DIFF_W'({2'b00, req.target});
        if (req.target == vpt_pkg::POS_FULL && pos_reg < vpt_pkg::POS_FULL)
        begin
            goal = vpt_pkg::TARGET_OVER_OPEN;
        end
        else if (req.target == vpt_pkg::POS_CLOSED && pos_reg > vpt_pkg::POS_CLOSED)
        begin
            goal = vpt_pkg::TARGET_OVER_CLOSE;
        end
        diff = goal - vpt_pkg::DIFF_W'({2'b00, pos_reg});
        if (diff > vpt_pkg::DIFF_LIMIT_HI)
        begin
            diff_clamped = vpt_pkg::DIFF_LIMIT_HI;
        end
        else if (diff < vpt_pkg::DIFF_LIMIT_LO)
        begin
            diff_clamped = vpt_pkg::DIFF_LIMIT_LO;
        end
        else
        begin
            diff_clamped = diff;
        end
    end

    assign diff_ext = vpt_pkg::RUN_W'(diff_clamped);

    always_comb
    begin
        run_next   = run_reg;
        phase_next = phase_reg;
        pos_next   = pos_reg;
        open_next  = open_reg;
        close_next = close_reg;
        case (req.op)
            vpt_pkg::OP_SET:
            begin
                run_next   = vpt_pkg::RUN_W'(diff_ext
                             * $signed(vpt_pkg::RUN_W'(vpt_pkg::CYCLES_PER_PERCENT)));
                phase_next = '0;
            end
            vpt_pkg::OP_TICK:
            begin
                if (run_reg > 0)
                begin
                    open_next  = 1'b1;
                    close_next = 1'b0;
                    if (on_boundary && pos_reg < vpt_pkg::POS_FULL)
                    begin
                        pos_next = pos_reg + vpt_pkg::POS_W'(1);
                    end
                    run_next   = run_reg - vpt_pkg::RUN_W'(1);
                    phase_next = phase_step;
                end
                else if (run_reg < 0)
                begin
                    open_next  = 1'b0;
                    close_next = 1'b1;
                    if (on_boundary && pos_reg > vpt_pkg::POS_CLOSED)
                    begin
                        pos_next = pos_reg - vpt_pkg::POS_W'(1);
                    end
                    run_next   = run_reg + vpt_pkg::RUN_W'(1);
                    phase_next = phase_step;
                end
                else
                begin
                    open_next  = 1'b0;
                    close_next = 1'b0;
                end
            end
            default:
            begin
                run_next = run_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= '0;
            phase_reg <= '0;
            pos_reg   <= '0;
            open_reg  <= 1'b0;
            close_reg <= 1'b0;
        end
        else if (fire)
        begin
            run_reg   <= run_next;
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            open_reg  <= open_next;
            close_reg <= close_next;
        end
    end

    assign run_wide = 32'(run_next);

    always_comb
    begin
        result.open_drive  = open_next;
        result.close_drive = close_next;
        result.position    = pos_next;
        if (run_wide > vpt_pkg::REM_HI)
        begin
            result.remaining = vpt_pkg::REM_HI[vpt_pkg::REM_W-1:0];
        end
        else if (run_wide < vpt_pkg::REM_LO)
        begin
            result.remaining = vpt_pkg::REM_LO[vpt_pkg::REM_W-1:0];
        end
        else
        begin
            result.remaining = run_wide[vpt_pkg::REM_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== src/vpt_out_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none

module vpt_out_stage (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    input  wire vpt_pkg::result_t result,
    output logic                  advance,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output vpt_pkg::result_t      out_result
);

    logic             valid_reg;
    logic             valid_next;
    logic             room;
    vpt_pkg::result_t result_reg;

    assign room       = !valid_reg || !out_stall;
    assign advance    = room;
    assign valid_next = room ? req_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (room && req_valid)
        begin
            result_reg <= result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

`default_nettype wire

// ===== src/valve_position_timer.sv =====
// Valve position timer.
// The input channel takes one request per cycle while in_stall is low: op
// selects a tick or a new target opening in percent. Every request yields
// exactly one result on the output channel with the drive lines, the
// estimated position and the signed number of drive ticks still to run.
// A request accepted at a clock edge is held in the input register, worked
// out by the core and captured in the result register when it has room.
// Throughput is one request per cycle while the output is not stalled, set
// by the single pass through the state update between the two registers.
// When the receiver stalls, the result register holds its value, and the
// input register holds one more request; in_stall rises only while both are
// full and the output is stalled.
// Reset clears the run count, the position estimate and both drive lines,
// and empties both registers.
`timescale 1ns / 1ps
`default_nettype none

module valve_position_timer (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic                            op,
    input  wire logic [vpt_pkg::TARGET_W-1:0]    target,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic                                 open_drive,
    output logic                                 close_drive,
    output logic [vpt_pkg::POS_W-1:0]            position,
    output logic signed [vpt_pkg::REM_W-1:0]     remaining
);

    vpt_pkg::request_t in_req;
    vpt_pkg::request_t req;
    vpt_pkg::result_t  result;
    vpt_pkg::result_t  out_result;
    logic              req_valid;
    logic              advance;

    assign in_req.op     = op;
    assign in_req.target = target;

    vpt_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_req    (in_req),
        .advance   (advance),
        .req_valid (req_valid),
        .req       (req)
    );

    vpt_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (req_valid && advance),
        .req    (req),
        .result (result)
    );

    vpt_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .result     (result),
        .advance    (advance),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_result (out_result)
    );

    assign open_drive  = out_result.open_drive;
    assign close_drive = out_result.close_drive;
    assign position    = out_result.position;
    assign remaining   = out_result.remaining;

endmodule

`default_nettype wire

// ===== src/vpt_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module vpt_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_valid,
    input wire logic                        in_stall,
    input wire logic                        out_valid,
    input wire logic                        out_stall,
    input wire logic                        open_drive,
    input wire logic                        close_drive,
    input wire logic [vpt_pkg::POS_W-1:0]   position,
    input wire logic [vpt_pkg::REM_W-1:0]   remaining
);

    // A stalled result stays in place unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(position)
            && $stable(remaining) && $stable(open_drive) && $stable(close_drive))
        else $error("stalled result changed");

    // Back pressure reaches the input only when the result register is blocked.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while output could move");

    // The motor is never driven both ways at once.
    a_drive_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(open_drive && close_drive))
        else $error("open and close driven together");

    // The position estimate saturates at fully open.
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> position <= vpt_pkg::POS_FULL)
        else $error("position beyond fully open");

    // A request accepted while no result is waiting reaches the output through the input and result registers.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !out_valid |-> ##2 out_valid)
        else $error("result missing after accepted request");

endmodule

bind valve_position_timer vpt_checker u_vpt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .open_drive  (open_drive),
    .close_drive (close_drive),
    .position    (position),
    .remaining   (remaining)
);

`default_nettype wire
